// ===== hdl/kvt_pkg.sv =====
// ============================================================================
// kvt_pkg
// Shared types and constants of the key/value table: table size, the beat
// that walks the cell chain, the insert port and the operation codes.
// ============================================================================
`default_nettype none

package kvt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic             vld;
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             found;
    logic [VAL_W-1:0] val_out;
    logic             free_seen;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] pos;
  } token_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } wr_t;

endpackage

`default_nettype wire

// ===== hdl/kvt_cell.sv =====
// ============================================================================
// kvt_cell
// One table entry. Compares the passing beat against its key, updates or
// frees itself on a hit, marks itself as the first free entry, and hands
// the beat to the next cell. Takes inserts from the shared write port.
// ============================================================================
`default_nettype none

module kvt_cell import kvt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IDX_W-1:0] idx_i,
  input  wire token_t           tok_i,
  input  wire wr_t              wr_i,
  output token_t                tok_o
);

  logic             valid_q, valid_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] value_q, value_d;
  logic             tok_vld_q;
  token_t           tok_q, tok_d;
  logic             op_ok;
  logic             match;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    tok_d.pos = tok_i.pos + 1'b1;
    op_ok = (tok_i.op == OP_ADD) || (tok_i.op == OP_SEARCH) || (tok_i.op == OP_REMOVE);
    match = tok_i.vld && op_ok && valid_q && (key_q == tok_i.key) && !tok_i.found;
    if (match) begin
      tok_d.found   = 1'b1;
      tok_d.val_out = value_q;
      if (tok_i.op == OP_ADD) begin
        value_d = tok_i.value;
      end
      if (tok_i.op == OP_REMOVE) begin
        valid_d = 1'b0;
      end
    end
    if (tok_i.vld && !valid_q && !tok_i.free_seen) begin
      tok_d.free_seen = 1'b1;
      tok_d.free_idx  = tok_i.pos;
    end
    if (wr_i.en && (wr_i.idx == idx_i)) begin
      valid_d = 1'b1;
      key_d   = wr_i.key;
      value_d = wr_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      tok_vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    tok_q   <= tok_d;
  end

  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

`default_nettype wire

// ===== hdl/key_value_table.sv =====
// ============================================================================
// key_value_table
// Bounded map of unique keys to values built as a row of entry cells.
// ============================================================================
// One item at a time: a beat is taken only while idle, and it walks the cell
// chain one cell per cycle; then the finish state does insert and count,
// waiting there while the previous result is still held on the output.
// A new item is taken while the previous result waits on the output.
// Reset clears all entry valid marks, the pair count and the handshakes.
`default_nettype none

module key_value_table import kvt_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [OP_W-1:0]    operation_i,
  input  wire logic [KEY_W-1:0]   key_i,
  input  wire logic [VAL_W-1:0]   value_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    found_o,
  output logic [VAL_W-1:0]        value_out_o,
  output logic                    full_refused_o,
  output logic [COUNT_W-1:0]      entry_count_o
);

  state_e             state_q, state_d;
  token_t             tok [CAPACITY+1];
  token_t             done_q, done_d;
  wr_t                wr;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic               found_q, found_d;
  logic [VAL_W-1:0]   value_q, value_d;
  logic               refused_q, refused_d;
  logic [COUNT_W-1:0] cnt_out_q, cnt_out_d;
  logic               insert;
  logic               remove_hit;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    tok[0]           = '0;
    tok[0].vld       = in_valid_i && in_ready_o;
    tok[0].op        = operation_i;
    tok[0].key       = key_i;
    tok[0].value     = value_in_i;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kvt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(i)),
      .tok_i  (tok[i]),
      .wr_i   (wr),
      .tok_o  (tok[i+1])
    );
  end

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    value_d     = value_q;
    refused_d   = refused_q;
    cnt_out_d   = cnt_out_q;
    wr          = '0;
    insert      = (done_q.op == OP_ADD) && !done_q.found && done_q.free_seen;
    remove_hit  = (done_q.op == OP_REMOVE) && done_q.found;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (tok[0].vld) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (tok[CAPACITY].vld) begin
          done_d  = tok[CAPACITY];
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          if (insert) begin
            wr.en    = 1'b1;
            wr.idx   = done_q.free_idx;
            wr.key   = done_q.key;
            wr.value = done_q.value;
            count_d  = count_q + 1'b1;
          end else if (remove_hit && (count_q != '0)) begin
            count_d = count_q - 1'b1;
          end
          out_valid_d = 1'b1;
          found_d     = done_q.found;
          value_d     = done_q.val_out;
          refused_d   = (done_q.op == OP_ADD) && !done_q.found && !done_q.free_seen;
          cnt_out_d   = COUNT_W'(count_d);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    done_q    <= done_d;
    found_q   <= found_d;
    value_q   <= value_d;
    refused_q <= refused_d;
    cnt_out_q <= cnt_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign value_out_o    = value_q;
  assign full_refused_o = refused_q;
  assign entry_count_o  = cnt_out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("pair count above capacity");

  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_WALK)
    else $error("accepted beat did not start a walk");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result raised outside finish");

  a_refuse_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(found_q && refused_q))
    else $error("refused add reported a hit");

endmodule

`default_nettype wire
